>>> sv/sparse_poly_multiply_assert.svh
// Assertion macros used by sparse_poly_multiply.
`ifndef SPARSE_POLY_MULTIPLY_ASSERT_SVH
`define SPARSE_POLY_MULTIPLY_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SPM_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the next cycle.
`define SPM_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> sv/spm_pkg.sv
// ----------------------------------------------------------------------------
// spm_pkg
// Shared constants of the sparse polynomial multiplier.
// ----------------------------------------------------------------------------
package spm_pkg;
    localparam int MaxTerms  = 8;
    localparam int ProdDepth = MaxTerms * MaxTerms;
    localparam int TIdxW     = $clog2(MaxTerms);
    localparam int TCntW     = $clog2(MaxTerms + 1);
    localparam int PIdxW     = $clog2(ProdDepth);
    localparam int PCntW     = $clog2(ProdDepth + 1);
    localparam int CoefW     = 16;
    localparam int ExponW    = 16;
    localparam int PCoefW    = 35;
    localparam int PExponW   = 17;
    // Running sums are kept wide enough that 64 merged extreme products
    // never wrap, so the test for a cancelled term is exact.
    localparam int SumW      = 38;
endpackage

>>> sv/spm_mult.sv
// ----------------------------------------------------------------------------
// spm_mult
// Registered 16 x 16 signed multiply and exponent add for one term pair.
// ----------------------------------------------------------------------------
module spm_mult
(
    input  logic                                   clk,
    input  logic signed [spm_pkg::CoefW-1:0]       a_coef,
    input  logic        [spm_pkg::ExponW-1:0]      a_expon,
    input  logic signed [spm_pkg::CoefW-1:0]       b_coef,
    input  logic        [spm_pkg::ExponW-1:0]      b_expon,
    output logic signed [spm_pkg::PCoefW-1:0]      p_coef,
    output logic        [spm_pkg::PExponW-1:0]     p_expon
);
    logic signed [2*spm_pkg::CoefW-1:0] prod_next;

    assign prod_next = a_coef * b_coef;

    always_ff @(posedge clk)
    begin
        p_coef  <= spm_pkg::PCoefW'(prod_next);
        p_expon <= {1'b0, a_expon} + {1'b0, b_expon};
    end
endmodule

>>> sv/sparse_poly_multiply.sv
// ----------------------------------------------------------------------------
// sparse_poly_multiply
// Product of two sparse polynomials with a sorted, merging product list.
// ----------------------------------------------------------------------------
// Usage: drive one term beat with start while busy is low. Terms of the first
// polynomial (mode 0) and then the second (mode 1) are stored one per cycle;
// beyond eight terms per list they are dropped. The beat with mode 1 and
// list_end set closes the pair: busy rises and the block forms all pairwise
// products through one shared multiplier. Each product is inserted into a
// product list held in a memory with registered reads. A sequencer walks the
// list one entry a cycle to find the place, then shifts the tail one entry a
// cycle to open a gap or to close one left by a merge that summed to zero.
// The sorted-insertion walk sets the time from the closing beat to the last
// result. Results leave one per cycle on the result ports, marked by
// out_valid, in descending exponent order, last_result on the final one. An
// empty product gives one beat with zero_product set. The receiver cannot
// stall: results are simply presented for one cycle each. Reset clears all
// counts and the sequencer; stored terms need no clearing since only counted
// entries are read.
`include "sparse_poly_multiply_assert.svh"
module sparse_poly_multiply
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                mode,
    input  logic signed [spm_pkg::CoefW-1:0]    term_coef,
    input  logic        [spm_pkg::ExponW-1:0]   term_expon,
    input  logic                                list_end,
    input  logic                                no_term,
    output logic                                out_valid,
    output logic signed [spm_pkg::PCoefW-1:0]   prod_coef,
    output logic        [spm_pkg::PExponW-1:0]  prod_expon,
    output logic                                last_result,
    output logic                                zero_product
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MUL   = 8'b0000_0010,
        S_WAIT  = 8'b0000_0100,
        S_SRCH  = 8'b0000_1000,
        S_OPEN  = 8'b0001_0000,
        S_CLOSE = 8'b0010_0000,
        S_NEXT  = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic signed [spm_pkg::CoefW-1:0]   a_coef_mem [spm_pkg::MaxTerms];
    logic        [spm_pkg::ExponW-1:0]  a_exp_mem  [spm_pkg::MaxTerms];
    logic signed [spm_pkg::CoefW-1:0]   b_coef_mem [spm_pkg::MaxTerms];
    logic        [spm_pkg::ExponW-1:0]  b_exp_mem  [spm_pkg::MaxTerms];
    logic signed [spm_pkg::SumW-1:0]    p_coef_mem [spm_pkg::ProdDepth];
    logic        [spm_pkg::PExponW-1:0] p_exp_mem  [spm_pkg::ProdDepth];

    logic [spm_pkg::TCntW-1:0] a_cnt_reg, b_cnt_reg;
    logic [spm_pkg::TCntW-1:0] i_reg, j_reg;
    logic [spm_pkg::PCntW-1:0] p_cnt_reg, k_reg, m_reg;

    logic signed [spm_pkg::PCoefW-1:0]  mc;
    logic        [spm_pkg::PExponW-1:0] me;
    logic signed [spm_pkg::SumW-1:0]    pc_reg;
    logic        [spm_pkg::PExponW-1:0] pe_reg;
    logic signed [spm_pkg::SumW-1:0]    rd_coef_reg;
    logic        [spm_pkg::PExponW-1:0] rd_exp_reg;
    logic signed [spm_pkg::SumW-1:0]    sum;
    logic [spm_pkg::PIdxW-1:0]          k_idx, m_idx, rd_addr;
    logic                               srch_in, srch_more, srch_hit;

    logic accept;
    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    spm_mult u_mult
    (
        .clk     (clk),
        .a_coef  (a_coef_mem[i_reg[spm_pkg::TIdxW-1:0]]),
        .a_expon (a_exp_mem[i_reg[spm_pkg::TIdxW-1:0]]),
        .b_coef  (b_coef_mem[j_reg[spm_pkg::TIdxW-1:0]]),
        .b_expon (b_exp_mem[j_reg[spm_pkg::TIdxW-1:0]]),
        .p_coef  (mc),
        .p_expon (me)
    );

    assign k_idx = k_reg[spm_pkg::PIdxW-1:0];
    assign m_idx = m_reg[spm_pkg::PIdxW-1:0];
    assign sum   = rd_coef_reg + pc_reg;

    // The read register holds entry k during the search. Entries at or
    // beyond the count are never looked at.
    assign srch_in   = (k_reg < p_cnt_reg);
    assign srch_more = srch_in && (rd_exp_reg > pe_reg);
    assign srch_hit  = srch_in && (rd_exp_reg == pe_reg);

    // Read address for the next cycle: always one step ahead of the walk,
    // so a shift reads below (or above) the entry it writes.
    always_comb
    begin
        rd_addr = '0;
        case (state_reg)
            S_SRCH:
            begin
                if (srch_more || srch_hit)
                    rd_addr = k_idx + spm_pkg::PIdxW'(1);
                else
                    rd_addr = spm_pkg::PIdxW'(p_cnt_reg - spm_pkg::PCntW'(1));
            end
            S_OPEN:  rd_addr = m_idx - spm_pkg::PIdxW'(2);
            S_CLOSE: rd_addr = m_idx + spm_pkg::PIdxW'(2);
            S_EMIT:  rd_addr = m_idx + spm_pkg::PIdxW'(1);
            default: rd_addr = '0;
        endcase
    end

    // Load path: store terms while idle.
    always_ff @(posedge clk)
    begin
        if (accept && !no_term) begin
            if (!mode && a_cnt_reg < spm_pkg::TCntW'(spm_pkg::MaxTerms)) begin
                a_coef_mem[a_cnt_reg[spm_pkg::TIdxW-1:0]] <= term_coef;
                a_exp_mem[a_cnt_reg[spm_pkg::TIdxW-1:0]]  <= term_expon;
            end
            if (mode && b_cnt_reg < spm_pkg::TCntW'(spm_pkg::MaxTerms)) begin
                b_coef_mem[b_cnt_reg[spm_pkg::TIdxW-1:0]] <= term_coef;
                b_exp_mem[b_cnt_reg[spm_pkg::TIdxW-1:0]]  <= term_expon;
            end
        end
    end

    // Product list: one registered read and at most one write per cycle.
    always_ff @(posedge clk)
    begin
        rd_coef_reg <= p_coef_mem[rd_addr];
        rd_exp_reg  <= p_exp_mem[rd_addr];
        case (state_reg)
            S_WAIT:
            begin
                pc_reg <= spm_pkg::SumW'(mc);
                pe_reg <= me;
            end
            S_SRCH:
            begin
                if (srch_hit && sum != '0)
                    p_coef_mem[k_idx] <= sum;
            end
            S_OPEN:
            begin
                if (m_reg > k_reg) begin
                    p_coef_mem[m_idx] <= rd_coef_reg;
                    p_exp_mem[m_idx]  <= rd_exp_reg;
                end else begin
                    p_coef_mem[k_idx] <= pc_reg;
                    p_exp_mem[k_idx]  <= pe_reg;
                end
            end
            S_CLOSE:
            begin
                if (m_reg + spm_pkg::PCntW'(1) < p_cnt_reg) begin
                    p_coef_mem[m_idx] <= rd_coef_reg;
                    p_exp_mem[m_idx]  <= rd_exp_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && mode && list_end)
                    state_next = S_NEXT;
            end
            S_NEXT:
            begin
                if (i_reg < a_cnt_reg && j_reg < b_cnt_reg)
                    state_next = S_MUL;
                else
                    state_next = S_EMIT;
            end
            S_MUL:   state_next = S_WAIT;
            S_WAIT:  state_next = S_SRCH;
            S_SRCH:
            begin
                if (srch_more)
                    state_next = S_SRCH;
                else if (srch_hit)
                    state_next = (sum == '0) ? S_CLOSE : S_NEXT;
                else
                    state_next = S_OPEN;
            end
            S_OPEN:
            begin
                if (m_reg <= k_reg)
                    state_next = S_NEXT;
            end
            S_CLOSE:
            begin
                if (m_reg + spm_pkg::PCntW'(2) >= p_cnt_reg)
                    state_next = S_NEXT;
            end
            S_EMIT:
            begin
                if (p_cnt_reg == '0 || m_reg + spm_pkg::PCntW'(1) >= p_cnt_reg)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            a_cnt_reg <= '0;
            b_cnt_reg <= '0;
            p_cnt_reg <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            m_reg     <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    i_reg     <= '0;
                    j_reg     <= '0;
                    p_cnt_reg <= '0;
                    if (accept && !no_term) begin
                        if (!mode && a_cnt_reg < spm_pkg::TCntW'(spm_pkg::MaxTerms))
                            a_cnt_reg <= a_cnt_reg + spm_pkg::TCntW'(1);
                        if (mode && b_cnt_reg < spm_pkg::TCntW'(spm_pkg::MaxTerms))
                            b_cnt_reg <= b_cnt_reg + spm_pkg::TCntW'(1);
                    end
                end
                S_NEXT:
                begin
                    k_reg <= '0;
                    m_reg <= '0;
                end
                S_MUL:
                begin
                    if (j_reg + spm_pkg::TCntW'(1) < b_cnt_reg) begin
                        j_reg <= j_reg + spm_pkg::TCntW'(1);
                    end else begin
                        j_reg <= '0;
                        i_reg <= i_reg + spm_pkg::TCntW'(1);
                    end
                end
                S_SRCH:
                begin
                    if (srch_more)
                        k_reg <= k_reg + spm_pkg::PCntW'(1);
                    else if (srch_hit)
                        m_reg <= k_reg;
                    else
                        m_reg <= p_cnt_reg;
                end
                S_OPEN:
                begin
                    if (m_reg > k_reg)
                        m_reg <= m_reg - spm_pkg::PCntW'(1);
                    else
                        p_cnt_reg <= p_cnt_reg + spm_pkg::PCntW'(1);
                end
                S_CLOSE:
                begin
                    m_reg <= m_reg + spm_pkg::PCntW'(1);
                    if (m_reg + spm_pkg::PCntW'(2) >= p_cnt_reg)
                        p_cnt_reg <= p_cnt_reg - spm_pkg::PCntW'(1);
                end
                S_EMIT:
                begin
                    m_reg <= m_reg + spm_pkg::PCntW'(1);
                    if (state_next == S_IDLE) begin
                        a_cnt_reg <= '0;
                        b_cnt_reg <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Result beat register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid <= 1'b0;
        end else begin
            out_valid <= (state_reg == S_EMIT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EMIT) begin
            if (p_cnt_reg == '0) begin
                prod_coef    <= '0;
                prod_expon   <= '0;
                last_result  <= 1'b1;
                zero_product <= 1'b1;
            end else begin
                prod_coef    <= rd_coef_reg[spm_pkg::PCoefW-1:0];
                prod_expon   <= rd_exp_reg;
                last_result  <= (m_reg + spm_pkg::PCntW'(1) >= p_cnt_reg);
                zero_product <= 1'b0;
            end
        end
    end

    `SPM_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1,
        a_cnt_reg <= spm_pkg::TCntW'(spm_pkg::MaxTerms))
    `SPM_ASSERT_IMP(p_cnt_bound, clk, rst_n, 1'b1,
        p_cnt_reg <= spm_pkg::PCntW'(spm_pkg::ProdDepth))
    `SPM_ASSERT_NEXT(busy_after_close, clk, rst_n, accept && mode && list_end, busy)
    `SPM_ASSERT_IMP(zero_is_last, clk, rst_n, out_valid && zero_product, last_result)
endmodule
